// ===== rtl/core/sgad_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgad_pkg
// Shared types and constants for the stick gesture arm detector: field
// widths, configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package sgad_pkg;

	// Field widths
	localparam int unsigned StickW = 12;
	localparam int unsigned TickW  = 8;
	localparam int unsigned HoldW  = 16;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_STICK_HIGH       = 3'd0,
		CFG_STICK_LOW        = 3'd1,
		CFG_CENTRE_MIN       = 3'd2,
		CFG_CENTRE_MAX       = 3'd3,
		CFG_PRELOCK_THROTTLE = 3'd4,
		CFG_ARM_HOLD_MS      = 3'd5,
		CFG_DISARM_HOLD_MS   = 3'd6
	} cfg_idx_t;

	// Register reset values
	localparam logic [StickW-1:0] StickHighRst       = 12'd1900;
	localparam logic [StickW-1:0] StickLowRst        = 12'd1100;
	localparam logic [StickW-1:0] CentreMinRst       = 12'd1400;
	localparam logic [StickW-1:0] CentreMaxRst       = 12'd1600;
	localparam logic [StickW-1:0] PrelockThrottleRst = 12'd1200;
	localparam logic [HoldW-1:0]  ArmHoldRst         = 16'd1000;
	localparam logic [HoldW-1:0]  DisarmHoldRst      = 16'd300;

	// Hold timer saturation value
	localparam logic [HoldW-1:0] HoldMax = {HoldW{1'b1}};

	// One result transaction
	typedef struct packed {
		logic arm_request;
		logic disarm_request;
		logic level_cal_request;
		logic reset_request;
		logic yaw_centred;
		logic prelock_active;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/stick_gesture_arm_detector_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stick_gesture_arm_detector_core
// Detects arm, disarm, level calibration and reset stick gestures from one
// control tick per transaction and emits one result transaction per tick.
// ----------------------------------------------------------------------------
// The block takes one tick transaction per clock cycle while the result
// channel keeps taking results, and returns exactly one result transaction
// for each, in order. A tick is captured in an input register; once the
// result register is free or draining, a single pass of comparators and one
// 16-bit saturating add updates the hold timer and gesture flags and loads
// the result register, which drives the output. A stalled output only holds
// the input side once both the input and result registers are full.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while no tick is in flight, which the block does not enforce;
// indexes past the last register are ignored.
module stick_gesture_arm_detector_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write port
	input  wire logic                               cfg_we,
	input  wire logic [sgad_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire logic [sgad_pkg::CfgDataW-1:0]      cfg_data,
	// tick channel
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [sgad_pkg::StickW-1:0]        roll_stick,
	input  wire logic [sgad_pkg::StickW-1:0]        pitch_stick,
	input  wire logic [sgad_pkg::StickW-1:0]        throttle_stick,
	input  wire logic [sgad_pkg::StickW-1:0]        yaw_stick,
	input  wire logic [sgad_pkg::TickW-1:0]         tick_ms,
	input  wire logic                               link_lost,
	input  wire logic                               armed,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    arm_request,
	output logic                                    disarm_request,
	output logic                                    level_cal_request,
	output logic                                    reset_request,
	output logic                                    yaw_centred,
	output logic                                    prelock_active
);

	// Configuration registers
	logic [sgad_pkg::StickW-1:0] stick_high_q;
	logic [sgad_pkg::StickW-1:0] stick_low_q;
	logic [sgad_pkg::StickW-1:0] centre_min_q;
	logic [sgad_pkg::StickW-1:0] centre_max_q;
	logic [sgad_pkg::StickW-1:0] prelock_throttle_q;
	logic [sgad_pkg::HoldW-1:0]  arm_hold_q;
	logic [sgad_pkg::HoldW-1:0]  disarm_hold_q;

	// Gesture state
	logic [sgad_pkg::HoldW-1:0] hold_timer_q;
	logic                       gesture_enabled_q;
	logic                       cal_done_q;
	logic                       last_centred_q;
	logic                       last_prelock_q;

	// Input stage
	logic                        valid_s1;
	logic [sgad_pkg::StickW-1:0] roll_s1;
	logic [sgad_pkg::StickW-1:0] pitch_s1;
	logic [sgad_pkg::StickW-1:0] throttle_s1;
	logic [sgad_pkg::StickW-1:0] yaw_s1;
	logic [sgad_pkg::TickW-1:0]  tick_s1;
	logic                        lost_s1;
	logic                        armed_s1;

	// Result stage
	logic              valid_s2;
	sgad_pkg::result_t result_s2;

	// Handshake
	logic adv_s1;
	logic adv_s2;

	// Next-state and result logic
	logic                       centred;
	logic                       prelock;
	logic                       base;
	logic                       toe_out;
	logic                       toe_in;
	logic                       low_left;
	logic                       low_right;
	logic                       gesture;
	logic                       enabled_now;
	logic [sgad_pkg::HoldW-1:0] hold_limit;
	logic [sgad_pkg::HoldW:0]   timer_sum;
	logic [sgad_pkg::HoldW-1:0] timer_sat;
	logic                       hold_reached;
	logic                       fire;
	logic [sgad_pkg::HoldW-1:0] timer_next;
	logic                       enabled_next;
	logic                       cal_done_next;
	logic                       cal_req;
	sgad_pkg::result_t          result_next;

	// Move a transaction forward when the next stage is free or draining
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_high_q       <= sgad_pkg::StickHighRst;
			stick_low_q        <= sgad_pkg::StickLowRst;
			centre_min_q       <= sgad_pkg::CentreMinRst;
			centre_max_q       <= sgad_pkg::CentreMaxRst;
			prelock_throttle_q <= sgad_pkg::PrelockThrottleRst;
			arm_hold_q         <= sgad_pkg::ArmHoldRst;
			disarm_hold_q      <= sgad_pkg::DisarmHoldRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sgad_pkg::CFG_STICK_HIGH:
					stick_high_q <= cfg_data[sgad_pkg::StickW-1:0];
				sgad_pkg::CFG_STICK_LOW:
					stick_low_q <= cfg_data[sgad_pkg::StickW-1:0];
				sgad_pkg::CFG_CENTRE_MIN:
					centre_min_q <= cfg_data[sgad_pkg::StickW-1:0];
				sgad_pkg::CFG_CENTRE_MAX:
					centre_max_q <= cfg_data[sgad_pkg::StickW-1:0];
				sgad_pkg::CFG_PRELOCK_THROTTLE:
					prelock_throttle_q <= cfg_data[sgad_pkg::StickW-1:0];
				sgad_pkg::CFG_ARM_HOLD_MS:
					arm_hold_q <= cfg_data[sgad_pkg::HoldW-1:0];
				sgad_pkg::CFG_DISARM_HOLD_MS:
					disarm_hold_q <= cfg_data[sgad_pkg::HoldW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Track input stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the tick payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			roll_s1     <= roll_stick;
			pitch_s1    <= pitch_stick;
			throttle_s1 <= throttle_stick;
			yaw_s1      <= yaw_stick;
			tick_s1     <= tick_ms;
			lost_s1     <= link_lost;
			armed_s1    <= armed;
		end
	end

	// Classify the stick positions
	always_comb begin
		centred   = (yaw_s1 > centre_min_q) && (yaw_s1 < centre_max_q);
		prelock   = (throttle_s1 < prelock_throttle_q) && !centred;
		base      = (pitch_s1 < stick_low_q) && (throttle_s1 < stick_low_q);
		toe_out   = base && (roll_s1 > stick_high_q) && (yaw_s1 < stick_low_q);
		toe_in    = base && (yaw_s1 > stick_high_q) && (roll_s1 < stick_low_q);
		low_left  = base && (yaw_s1 < stick_low_q) && (roll_s1 < stick_low_q);
		low_right = base && (yaw_s1 > stick_high_q) && (roll_s1 > stick_high_q);
		gesture   = toe_out || toe_in;
	end

	// Run the hold timer and decide arm/disarm
	always_comb begin
		enabled_now  = gesture_enabled_q || centred;
		hold_limit   = armed_s1 ? disarm_hold_q : arm_hold_q;
		timer_sum    = {1'b0, hold_timer_q} + {{(sgad_pkg::HoldW + 1 - sgad_pkg::TickW){1'b0}},
			tick_s1};
		timer_sat    = timer_sum[sgad_pkg::HoldW] ? sgad_pkg::HoldMax
			: timer_sum[sgad_pkg::HoldW-1:0];
		hold_reached = !(hold_timer_q < hold_limit);
		fire         = enabled_now && gesture && hold_reached;
		timer_next   = hold_timer_q;
		enabled_next = enabled_now;
		if (enabled_now) begin
			if (!gesture || hold_reached) begin
				timer_next = '0;
			end else begin
				timer_next = timer_sat;
			end
			if (fire) begin
				enabled_next = 1'b0;
			end
		end
	end

	// Level calibration once per gesture, only while disarmed
	always_comb begin
		cal_req       = 1'b0;
		cal_done_next = cal_done_q;
		if (!armed_s1) begin
			cal_req       = low_left && !cal_done_q;
			cal_done_next = low_left;
		end
	end

	// Assemble the result, holding indicators while the link is lost
	always_comb begin
		if (lost_s1) begin
			result_next                   = '0;
			result_next.yaw_centred       = last_centred_q;
			result_next.prelock_active    = last_prelock_q;
		end else begin
			result_next.arm_request       = fire && !armed_s1;
			result_next.disarm_request    = fire && armed_s1;
			result_next.level_cal_request = cal_req;
			result_next.reset_request     = low_right && !armed_s1;
			result_next.yaw_centred       = centred;
			result_next.prelock_active    = prelock;
		end
	end

	// Update gesture state once per tick with a live link
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_timer_q      <= '0;
			gesture_enabled_q <= 1'b0;
			cal_done_q        <= 1'b0;
			last_centred_q    <= 1'b0;
			last_prelock_q    <= 1'b0;
		end else if (adv_s1 && !lost_s1) begin
			hold_timer_q      <= timer_next;
			gesture_enabled_q <= enabled_next;
			cal_done_q        <= cal_done_next;
			last_centred_q    <= centred;
			last_prelock_q    <= prelock;
		end
	end

	// Track result stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result_next;
		end
	end

	// Drive the result channel
	assign out_valid         = valid_s2;
	assign arm_request       = result_s2.arm_request;
	assign disarm_request    = result_s2.disarm_request;
	assign level_cal_request = result_s2.level_cal_request;
	assign reset_request     = result_s2.reset_request;
	assign yaw_centred       = result_s2.yaw_centred;
	assign prelock_active    = result_s2.prelock_active;

	// Arm and disarm requests never come together
	a_arm_disarm_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(result_s2.arm_request && result_s2.disarm_request))
		else $error("arm and disarm requested in the same transaction");

	// A fired request clears the timer and disables gestures
	a_fire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !lost_s1 && fire) |=> (!gesture_enabled_q && hold_timer_q == '0))
		else $error("gesture state not cleared after request");

	// A lost-link tick leaves the hold timer alone
	a_lost_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && lost_s1) |=> $stable(hold_timer_q) && $stable(gesture_enabled_q))
		else $error("gesture state changed on lost-link tick");

	// A lost-link tick carries no request
	a_lost_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && lost_s1) |=> !(result_s2.arm_request || result_s2.disarm_request
			|| result_s2.level_cal_request || result_s2.reset_request))
		else $error("request emitted on lost-link tick");

endmodule
`default_nettype wire
